// ===== rtl/core/erbp_pkg.sv =====
`timescale 1ns / 1ps
package erbp_pkg;

    localparam int CW = 16;            // coordinate width
    localparam int AW = 16;            // angle register width
    localparam int AF = 14;            // angle fraction bits
    localparam int CFG_IW = 3;         // config index width

    typedef logic [CFG_IW-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_COS    = 3'd0;
    localparam t_cfg_idx CFG_SIN    = 3'd1;
    localparam t_cfg_idx CFG_AXIS_X = 3'd2;
    localparam t_cfg_idx CFG_AXIS_Y = 3'd3;
    localparam t_cfg_idx CFG_CEN_X  = 3'd4;
    localparam t_cfg_idx CFG_CEN_Y  = 3'd5;

    localparam logic signed [AW-1:0] COS_RST  = 16'sd16384;
    localparam logic [CW-1:0]        AXIS_RST = 16'd16;

    // larger normalized offset component lies in [2^NB, 2^(NB+1))
    localparam int NB = 14;

endpackage

// ===== rtl/core/ellipse_ray_boundary_point_core.sv =====
`timescale 1ns / 1ps
// Ray / rotated-ellipse boundary point. Each beat carries one query point; the block
// returns the point where the ray from the ellipse centre toward it meets the boundary,
// saturated to 16 bits, or a degenerate flag with zero coordinates when the offset or an
// axis is zero. One point is accepted every clock while the output buffer is not full;
// results pass through the 32-stage square root and the two 17-stage dividers. A
// two-entry output buffer keeps the pipe moving while one result waits to be taken.
module ellipse_ray_boundary_point_core
    import erbp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IW-1:0]    i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic signed [CW-1:0] i_point_x,
    input  logic signed [CW-1:0] i_point_y,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [CW-1:0] o_boundary_x,
    output logic signed [CW-1:0] o_boundary_y,
    output logic                 o_degenerate
);

    localparam int XW = CW + 4;        // offset after rotation and centre subtract
    localparam int MW = CW + 3;        // offset magnitude
    localparam int UW = NB + 1;        // normalized magnitude
    localparam int TW = CW + UW;       // axis * offset
    localparam int SQ = 2 * TW;        // squared term
    localparam int DW = 32;            // root width
    localparam int PW = 2 * CW;        // a*b
    localparam int NW = UW + PW + 1;   // rounded numerator
    localparam int QW = CW + 1;        // quotient
    localparam int OW = QW + 2;        // signed x before final rotation
    localparam int FW = OW + AW + 1;   // final products sum
    localparam int RS = FW - AF;       // after rounding shift

    // ---------------- configuration ----------------
    logic signed [AW-1:0] r_cos, r_sin;
    logic [CW-1:0]        r_axis_x, r_axis_y;
    logic signed [CW-1:0] r_cen_x, r_cen_y;
    logic [PW-1:0]        r_ab;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos    <= COS_RST;
            r_sin    <= '0;
            r_axis_x <= AXIS_RST;
            r_axis_y <= AXIS_RST;
            r_cen_x  <= '0;
            r_cen_y  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COS:    r_cos    <= i_cfg_data;
                CFG_SIN:    r_sin    <= i_cfg_data;
                CFG_AXIS_X: r_axis_x <= i_cfg_data;
                CFG_AXIS_Y: r_axis_y <= i_cfg_data;
                CFG_CEN_X:  r_cen_x  <= i_cfg_data;
                CFG_CEN_Y:  r_cen_y  <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_ab <= r_axis_x * r_axis_y;
    end

    // ---------------- flow control ----------------
    logic [1:0] r_cnt;
    logic       en;
    assign en         = (r_cnt != 2'd2);
    assign o_in_ready = en;

    // ---------------- S1: input rotation products ----------------
    logic                 r1_v;
    logic signed [PW-1:0] r1_pcx, r1_psy, r1_psx, r1_pcy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else if (en)  r1_v <= i_in_valid;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_pcx <= i_point_x * r_cos;
            r1_psy <= i_point_y * r_sin;
            r1_psx <= i_point_x * r_sin;
            r1_pcy <= i_point_y * r_cos;
        end
    end

    // ---------------- S2: round, subtract centre ----------------
    logic                 r2_v, r2_dg;
    logic signed [XW-1:0] r2_xx, r2_yy;
    logic signed [PW:0]   n_sx, n_sy;
    logic signed [XW-1:0] n_xx, n_yy;

    always_comb begin
        n_sx = (PW+1)'(r1_pcx) - (PW+1)'(r1_psy) + (PW+1)'(1 << (AF-1));
        n_sy = (PW+1)'(r1_psx) + (PW+1)'(r1_pcy) + (PW+1)'(1 << (AF-1));
        n_xx = XW'(n_sx >>> AF) - XW'(r_cen_x);
        n_yy = XW'(n_sy >>> AF) - XW'(r_cen_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else if (en)  r2_v <= r1_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_xx <= n_xx;
            r2_yy <= n_yy;
            r2_dg <= (n_xx == '0 && n_yy == '0) || r_axis_x == '0 || r_axis_y == '0;
        end
    end

    // ---------------- S3: magnitudes ----------------
    logic          r3_v, r3_dg, r3_nx, r3_ny;
    logic [MW-1:0] r3_ax, r3_ay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else if (en)  r3_v <= r2_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_dg <= r2_dg;
            r3_nx <= r2_xx[XW-1];
            r3_ny <= r2_yy[XW-1];
            r3_ax <= r2_xx[XW-1] ? MW'(-r2_xx) : MW'(r2_xx);
            r3_ay <= r2_yy[XW-1] ? MW'(-r2_yy) : MW'(r2_yy);
        end
    end

    // ---------------- S4: normalize direction ----------------
    logic          r4_v, r4_dg, r4_nx, r4_ny;
    logic [UW-1:0] r4_ux, r4_uy;
    logic [MW-1:0] m;
    logic [4:0]    top;
    logic [MW-1:0] n_ux, n_uy;

    always_comb begin
        m   = (r3_ax > r3_ay) ? r3_ax : r3_ay;
        top = '0;
        for (int i = 0; i < MW; i++) begin
            if (m[i]) top = 5'(i);
        end
        if (top >= 5'(NB)) begin
            n_ux = r3_ax >> (top - 5'(NB));
            n_uy = r3_ay >> (top - 5'(NB));
        end else begin
            n_ux = r3_ax << (5'(NB) - top);
            n_uy = r3_ay << (5'(NB) - top);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_v <= 1'b0;
        else if (en)  r4_v <= r3_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_dg <= r3_dg;
            r4_nx <= r3_nx;
            r4_ny <= r3_ny;
            r4_ux <= n_ux[UW-1:0];
            r4_uy <= n_uy[UW-1:0];
        end
    end

    // ---------------- S5: axis products ----------------
    logic          r5_v, r5_dg, r5_nx, r5_ny;
    logic [UW-1:0] r5_ux, r5_uy;
    logic [TW-1:0] r5_tx, r5_ty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else if (en)  r5_v <= r4_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            {r5_dg, r5_nx, r5_ny, r5_ux, r5_uy} <= {r4_dg, r4_nx, r4_ny, r4_ux, r4_uy};
            r5_tx <= r_axis_y * r4_ux;
            r5_ty <= r_axis_x * r4_uy;
        end
    end

    // ---------------- S6: squares ----------------
    logic          r6_v, r6_dg, r6_nx, r6_ny;
    logic [UW-1:0] r6_ux, r6_uy;
    logic [SQ-1:0] r6_qx, r6_qy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_v <= 1'b0;
        else if (en)  r6_v <= r5_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            {r6_dg, r6_nx, r6_ny, r6_ux, r6_uy} <= {r5_dg, r5_nx, r5_ny, r5_ux, r5_uy};
            r6_qx <= r5_tx * r5_tx;
            r6_qy <= r5_ty * r5_ty;
        end
    end

    // ---------------- S7: radicand ----------------
    localparam int SDW = 3 + 2*UW;
    logic              r7_v;
    logic [2*DW-1:0]   r7_rad;
    logic [SDW-1:0]    r7_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_v <= 1'b0;
        else if (en)  r7_v <= r6_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_rad  <= (2*DW)'(r6_qx) + (2*DW)'(r6_qy);
            r7_side <= {r6_dg, r6_nx, r6_ny, r6_ux, r6_uy};
        end
    end

    // ---------------- square root ----------------
    logic           sq_v;
    logic [DW-1:0]  sq_root;
    logic [SDW-1:0] sq_side;

    erbp_isqrt #(.QW(DW), .SW(SDW)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r7_v),
        .i_rad   (r7_rad),
        .i_side  (r7_side),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // ---------------- S8: numerators ----------------
    logic            r8_v, r8_dg, r8_nx, r8_ny;
    logic [DW-1:0]   r8_d;
    logic [NW-2:0]   r8_mx, r8_my;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r8_v <= 1'b0;
        else if (en)  r8_v <= sq_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            {r8_dg, r8_nx, r8_ny} <= sq_side[SDW-1:2*UW];
            r8_d  <= (sq_root == '0) ? DW'(1) : sq_root;
            r8_mx <= sq_side[2*UW-1:UW] * r_ab;
            r8_my <= sq_side[UW-1:0] * r_ab;
        end
    end

    // ---------------- S9: add half divisor ----------------
    logic            r9_v, r9_dg, r9_nx, r9_ny;
    logic [DW-1:0]   r9_d;
    logic [NW-1:0]   r9_nmx, r9_nmy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r9_v <= 1'b0;
        else if (en)  r9_v <= r8_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            {r9_dg, r9_nx, r9_ny} <= {r8_dg, r8_nx, r8_ny};
            r9_d   <= r8_d;
            r9_nmx <= NW'(r8_mx) + NW'(r8_d >> 1);
            r9_nmy <= NW'(r8_my) + NW'(r8_d >> 1);
        end
    end

    // ---------------- dividers ----------------
    logic          dx_v, dy_v;
    logic [QW-1:0] dx_q, dy_q;
    logic [1:0]    dx_side;
    logic          dy_side;

    erbp_div #(.NW(NW), .DW(DW), .QW(QW), .SW(2)) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r9_v),
        .i_num   (r9_nmx),
        .i_den   (r9_d),
        .i_side  ({r9_dg, r9_nx}),
        .o_valid (dx_v),
        .o_quot  (dx_q),
        .o_side  (dx_side)
    );

    erbp_div #(.NW(NW), .DW(DW), .QW(QW), .SW(1)) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r9_v),
        .i_num   (r9_nmy),
        .i_den   (r9_d),
        .i_side  (r9_ny),
        .o_valid (dy_v),
        .o_quot  (dy_q),
        .o_side  (dy_side)
    );

    // ---------------- S10: sign, add centre ----------------
    logic                 r10_v, r10_dg;
    logic signed [OW-1:0] r10_x, r10_y;
    logic signed [OW-1:0] n_ox, n_oy;

    always_comb begin
        n_ox = dx_side[0] ? -$signed(OW'(dx_q)) : $signed(OW'(dx_q));
        n_oy = dy_side    ? -$signed(OW'(dy_q)) : $signed(OW'(dy_q));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r10_v <= 1'b0;
        else if (en)  r10_v <= dx_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_dg <= dx_side[1];
            r10_x  <= n_ox + OW'(r_cen_x);
            r10_y  <= n_oy + OW'(r_cen_y);
        end
    end

    // ---------------- S11: back-rotation products ----------------
    localparam int BW = OW + AW;
    logic                 r11_v, r11_dg;
    logic signed [BW-1:0] r11_xc, r11_ys, r11_yc, r11_xs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r11_v <= 1'b0;
        else if (en)  r11_v <= r10_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r11_dg <= r10_dg;
            r11_xc <= r10_x * BW'(r_cos);
            r11_ys <= r10_y * BW'(r_sin);
            r11_yc <= r10_y * BW'(r_cos);
            r11_xs <= r10_x * BW'(r_sin);
        end
    end

    // ---------------- S12: round, saturate ----------------
    localparam logic signed [RS-1:0] SAT_HI = RS'((1 << (CW-1)) - 1);
    localparam logic signed [RS-1:0] SAT_LO = -SAT_HI - RS'(1);

    logic                 r12_v, r12_dg;
    logic signed [CW-1:0] r12_bx, r12_by;
    logic signed [FW-1:0] n_fx, n_fy;
    logic signed [RS-1:0] n_rx, n_ry;
    logic signed [CW-1:0] n_bx, n_by;

    always_comb begin
        n_fx = FW'(r11_xc) + FW'(r11_ys) + FW'(1 << (AF-1));
        n_fy = FW'(r11_yc) - FW'(r11_xs) + FW'(1 << (AF-1));
        n_rx = RS'(n_fx >>> AF);
        n_ry = RS'(n_fy >>> AF);
        if (n_rx > SAT_HI)      n_bx = SAT_HI[CW-1:0];
        else if (n_rx < SAT_LO) n_bx = SAT_LO[CW-1:0];
        else                    n_bx = n_rx[CW-1:0];
        if (n_ry > SAT_HI)      n_by = SAT_HI[CW-1:0];
        else if (n_ry < SAT_LO) n_by = SAT_LO[CW-1:0];
        else                    n_by = n_ry[CW-1:0];
        if (r11_dg) begin
            n_bx = '0;
            n_by = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r12_v <= 1'b0;
        else if (en)  r12_v <= r11_v;
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r12_dg <= r11_dg;
            r12_bx <= n_bx;
            r12_by <= n_by;
        end
    end

    // ---------------- output buffer ----------------
    logic                 r_head;
    logic [2*CW:0]        r_buf [2];
    logic                 push, pop;
    logic                 tail;
    logic [2*CW:0]        head_beat;

    assign push      = en && r12_v;
    assign pop       = o_out_valid && i_out_ready;
    assign tail      = r_head ^ r_cnt[0];
    assign head_beat = r_buf[r_head];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_head <= 1'b0;
        end else begin
            r_cnt  <= r_cnt + {1'b0, push} - {1'b0, pop};
            if (pop) r_head <= ~r_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_buf[tail] <= {r12_dg, r12_bx, r12_by};
    end

    assign o_out_valid  = (r_cnt != 2'd0);
    assign o_degenerate = head_beat[2*CW];
    assign o_boundary_x = head_beat[2*CW-1:CW];
    assign o_boundary_y = head_beat[CW-1:0];

    // ---------------- checks ----------------
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("output buffer count out of range");

    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dx_v == dy_v)
        else $error("dividers out of step");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!en && r12_v) |=> r12_v)
        else $error("stalled result lost");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_degenerate) |-> (o_boundary_x == '0 && o_boundary_y == '0))
        else $error("degenerate result carries coordinates");

endmodule

// ===== rtl/core/erbp_isqrt.sv =====
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage.
module erbp_isqrt #(
    parameter int QW = 32,
    parameter int SW = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [2*QW-1:0]   i_rad,
    input  logic [SW-1:0]     i_side,
    output logic              o_valid,
    output logic [QW-1:0]     o_root,
    output logic [SW-1:0]     o_side
);

    localparam int RW = 2*QW;

    logic            r_vld  [QW];
    logic [QW+1:0]   r_rem  [QW];
    logic [QW-1:0]   r_root [QW];
    logic [RW-1:0]   r_rad  [QW];
    logic [SW-1:0]   r_side [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic            vin;
        logic [QW+1:0]   rem_in;
        logic [QW-1:0]   root_in;
        logic [RW-1:0]   rad_in;
        logic [SW-1:0]   side_in;
        logic [QW+1:0]   rem_sh;
        logic [QW+1:0]   trial;
        logic            take;

        if (k == 0) begin : g_first
            assign vin     = i_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
            assign side_in = i_side;
        end else begin : g_next
            assign vin     = r_vld[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign rad_in  = r_rad[k-1];
            assign side_in = r_side[k-1];
        end

        assign rem_sh = {rem_in[QW-1:0], rad_in[RW-1:RW-2]};
        assign trial  = {root_in, 2'b01};
        assign take   = (rem_sh >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= take ? rem_sh - trial : rem_sh;
                r_root[k] <= {root_in[QW-2:0], take};
                r_rad[k]  <= {rad_in[RW-3:0], 2'b00};
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_root  = r_root[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

// ===== rtl/core/erbp_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage.
// Caller guarantees the quotient fits in QW bits.
module erbp_div #(
    parameter int NW = 48,
    parameter int DW = 32,
    parameter int QW = 17,
    parameter int SW = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NW-1:0]     i_num,
    input  logic [DW-1:0]     i_den,
    input  logic [SW-1:0]     i_side,
    output logic              o_valid,
    output logic [QW-1:0]     o_quot,
    output logic [SW-1:0]     o_side
);

    logic            r_vld  [QW];
    logic [DW-1:0]   r_rem  [QW];
    logic [QW-1:0]   r_low  [QW];
    logic [QW-1:0]   r_quot [QW];
    logic [DW-1:0]   r_den  [QW];
    logic [SW-1:0]   r_side [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic            vin;
        logic [DW-1:0]   rem_in;
        logic [QW-1:0]   low_in;
        logic [QW-1:0]   quot_in;
        logic [DW-1:0]   den_in;
        logic [SW-1:0]   side_in;
        logic [DW:0]     rs;
        logic            take;

        if (k == 0) begin : g_first
            assign vin     = i_valid;
            assign rem_in  = DW'(i_num[NW-1:QW]);
            assign low_in  = i_num[QW-1:0];
            assign quot_in = '0;
            assign den_in  = i_den;
            assign side_in = i_side;
        end else begin : g_next
            assign vin     = r_vld[k-1];
            assign rem_in  = r_rem[k-1];
            assign low_in  = r_low[k-1];
            assign quot_in = r_quot[k-1];
            assign den_in  = r_den[k-1];
            assign side_in = r_side[k-1];
        end

        assign rs   = {rem_in, low_in[QW-1]};
        assign take = (rs >= {1'b0, den_in});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= take ? DW'(rs - {1'b0, den_in}) : rs[DW-1:0];
                r_low[k]  <= {low_in[QW-2:0], 1'b0};
                r_quot[k] <= {quot_in[QW-2:0], take};
                r_den[k]  <= den_in;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quot  = r_quot[QW-1];
    assign o_side  = r_side[QW-1];

endmodule
